@@ rtl/agps_pkg.sv @@
// ----------------------------------------------------------------------------
// agps_pkg
// Shared types, codes and the step program of the stencil update sequencer.
// ----------------------------------------------------------------------------
package agps_pkg;

    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_VALS  = 12;
    localparam int PROG_LEN  = 83;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;

    localparam logic [2:0] REG_DT   = 3'd0;
    localparam logic [2:0] REG_K2   = 3'd1;
    localparam logic [2:0] REG_CC   = 3'd2;
    localparam logic [2:0] REG_P    = 3'd3;
    localparam logic [2:0] REG_RR   = 3'd4;
    localparam logic [2:0] REG_I2DX = 3'd5;
    localparam logic [2:0] REG_IDX2 = 3'd6;

    typedef struct packed {
        logic [NUM_VALS-1:0][VAL_W-1:0] val;
        logic [7:0]                     sd;
        logic [1:0]                     mode;
        logic                           err;
        logic [11:0]                    index;
        logic                           last;
    } job_t;

    typedef struct packed {
        val_t dt;
        val_t k2;
        val_t cc;
        val_t p;
        val_t rr;
        val_t i2dx;
        val_t idx2;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } back_status_t;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MULQ  = 3'd2;
    localparam logic [2:0] OP_MUL0  = 3'd3;
    localparam logic [2:0] OP_HALFL = 3'd4;
    localparam logic [2:0] OP_HALFR = 3'd5;

    localparam logic [5:0] SRC_TML  = 6'd0;
    localparam logic [5:0] SRC_TMC  = 6'd1;
    localparam logic [5:0] SRC_TMR  = 6'd2;
    localparam logic [5:0] SRC_TFL  = 6'd3;
    localparam logic [5:0] SRC_TFC  = 6'd4;
    localparam logic [5:0] SRC_TFR  = 6'd5;
    localparam logic [5:0] SRC_ZL   = 6'd6;
    localparam logic [5:0] SRC_ZC   = 6'd7;
    localparam logic [5:0] SRC_ZR   = 6'd8;
    localparam logic [5:0] SRC_WL   = 6'd9;
    localparam logic [5:0] SRC_WC   = 6'd10;
    localparam logic [5:0] SRC_WR   = 6'd11;
    localparam logic [5:0] SRC_DT   = 6'd12;
    localparam logic [5:0] SRC_K2   = 6'd13;
    localparam logic [5:0] SRC_CC   = 6'd14;
    localparam logic [5:0] SRC_P    = 6'd15;
    localparam logic [5:0] SRC_RR   = 6'd16;
    localparam logic [5:0] SRC_I2DX = 6'd17;
    localparam logic [5:0] SRC_IDX2 = 6'd18;
    localparam logic [5:0] SRC_SD   = 6'd19;

    localparam logic [5:0] T_E0L  = 6'd32;
    localparam logic [5:0] T_E0R  = 6'd33;
    localparam logic [5:0] T_E1L  = 6'd34;
    localparam logic [5:0] T_E1R  = 6'd35;
    localparam logic [5:0] T_E2L  = 6'd36;
    localparam logic [5:0] T_E2R  = 6'd37;
    localparam logic [5:0] T_E3L  = 6'd38;
    localparam logic [5:0] T_E3R  = 6'd39;
    localparam logic [5:0] T_ML   = 6'd40;
    localparam logic [5:0] T_MC   = 6'd41;
    localparam logic [5:0] T_MR   = 6'd42;
    localparam logic [5:0] T_DTM  = 6'd43;
    localparam logic [5:0] T_DTF  = 6'd44;
    localparam logic [5:0] T_DZ   = 6'd45;
    localparam logic [5:0] T_DW   = 6'd46;
    localparam logic [5:0] T_DWTF = 6'd47;
    localparam logic [5:0] T_S    = 6'd48;
    localparam logic [5:0] T_S2   = 6'd49;
    localparam logic [5:0] T_LTM  = 6'd50;
    localparam logic [5:0] T_LTF  = 6'd51;
    localparam logic [5:0] T_LZ   = 6'd52;
    localparam logic [5:0] T_CDT  = 6'd53;
    localparam logic [5:0] T_PDT  = 6'd54;
    localparam logic [5:0] T_TMN  = 6'd55;
    localparam logic [5:0] T_TFN  = 6'd56;
    localparam logic [5:0] T_ZN   = 6'd57;
    localparam logic [5:0] T_A    = 6'd58;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] dst;
    } step_t;

    function automatic step_t mk(input logic [2:0] op, input logic [5:0] a,
                                 input logic [5:0] b, input logic [5:0] dst);
        step_t s;
        s.op  = op;
        s.a   = a;
        s.b   = b;
        s.dst = dst;
        return s;
    endfunction

    function automatic step_t prog_step(input logic [6:0] pc);
        step_t s;
        case (pc)
            7'd0:  s = mk(OP_HALFL, SRC_TML, SRC_TMC, T_E0L);
            7'd1:  s = mk(OP_HALFR, SRC_TMR, SRC_TMC, T_E0R);
            7'd2:  s = mk(OP_HALFL, SRC_TFL, SRC_TFC, T_E1L);
            7'd3:  s = mk(OP_HALFR, SRC_TFR, SRC_TFC, T_E1R);
            7'd4:  s = mk(OP_HALFL, SRC_ZL, SRC_ZC, T_E2L);
            7'd5:  s = mk(OP_HALFR, SRC_ZR, SRC_ZC, T_E2R);
            7'd6:  s = mk(OP_HALFL, SRC_WL, SRC_WC, T_E3L);
            7'd7:  s = mk(OP_HALFR, SRC_WR, SRC_WC, T_E3R);
            7'd8:  s = mk(OP_MULQ, SRC_WL, SRC_TFL, T_ML);
            7'd9:  s = mk(OP_MULQ, SRC_WC, SRC_TFC, T_MC);
            7'd10: s = mk(OP_MULQ, SRC_WR, SRC_TFR, T_MR);
            7'd11: s = mk(OP_HALFL, T_ML, T_MC, T_ML);
            7'd12: s = mk(OP_HALFR, T_MR, T_MC, T_MR);
            7'd13: s = mk(OP_SUB, T_E0R, T_E0L, T_S);
            7'd14: s = mk(OP_MULQ, T_S, SRC_I2DX, T_S);
            7'd15: s = mk(OP_MUL0, T_S, SRC_SD, T_DTM);
            7'd16: s = mk(OP_SUB, T_E1R, T_E1L, T_S);
            7'd17: s = mk(OP_MULQ, T_S, SRC_I2DX, T_S);
            7'd18: s = mk(OP_MUL0, T_S, SRC_SD, T_DTF);
            7'd19: s = mk(OP_SUB, T_E2R, T_E2L, T_S);
            7'd20: s = mk(OP_MULQ, T_S, SRC_I2DX, T_S);
            7'd21: s = mk(OP_MUL0, T_S, SRC_SD, T_DZ);
            7'd22: s = mk(OP_SUB, T_E3R, T_E3L, T_S);
            7'd23: s = mk(OP_MULQ, T_S, SRC_I2DX, T_S);
            7'd24: s = mk(OP_MUL0, T_S, SRC_SD, T_DW);
            7'd25: s = mk(OP_SUB, T_MR, T_ML, T_S);
            7'd26: s = mk(OP_MULQ, T_S, SRC_I2DX, T_S);
            7'd27: s = mk(OP_MUL0, T_S, SRC_SD, T_DWTF);
            7'd28: s = mk(OP_ADD, T_E0L, T_E0R, T_S);
            7'd29: s = mk(OP_ADD, SRC_TMC, SRC_TMC, T_S2);
            7'd30: s = mk(OP_SUB, T_S, T_S2, T_S);
            7'd31: s = mk(OP_MULQ, T_S, SRC_IDX2, T_S);
            7'd32: s = mk(OP_MUL0, T_S, SRC_SD, T_S);
            7'd33: s = mk(OP_MUL0, T_S, SRC_SD, T_LTM);
            7'd34: s = mk(OP_ADD, T_E1L, T_E1R, T_S);
            7'd35: s = mk(OP_ADD, SRC_TFC, SRC_TFC, T_S2);
            7'd36: s = mk(OP_SUB, T_S, T_S2, T_S);
            7'd37: s = mk(OP_MULQ, T_S, SRC_IDX2, T_S);
            7'd38: s = mk(OP_MUL0, T_S, SRC_SD, T_S);
            7'd39: s = mk(OP_MUL0, T_S, SRC_SD, T_LTF);
            7'd40: s = mk(OP_ADD, T_E2L, T_E2R, T_S);
            7'd41: s = mk(OP_ADD, SRC_ZC, SRC_ZC, T_S2);
            7'd42: s = mk(OP_SUB, T_S, T_S2, T_S);
            7'd43: s = mk(OP_MULQ, T_S, SRC_IDX2, T_S);
            7'd44: s = mk(OP_MUL0, T_S, SRC_SD, T_S);
            7'd45: s = mk(OP_MUL0, T_S, SRC_SD, T_LZ);
            7'd46: s = mk(OP_MULQ, SRC_CC, SRC_DT, T_CDT);
            7'd47: s = mk(OP_MULQ, SRC_P, SRC_DT, T_PDT);
            7'd48: s = mk(OP_MULQ, SRC_DT, T_LTM, T_A);
            7'd49: s = mk(OP_ADD, SRC_TMC, T_A, T_TMN);
            7'd50: s = mk(OP_MULQ, SRC_DT, T_DWTF, T_A);
            7'd51: s = mk(OP_SUB, T_TMN, T_A, T_TMN);
            7'd52: s = mk(OP_MULQ, SRC_DT, T_LTF, T_A);
            7'd53: s = mk(OP_ADD, SRC_TFC, T_A, T_TFN);
            7'd54: s = mk(OP_MULQ, SRC_DT, SRC_K2, T_A);
            7'd55: s = mk(OP_MULQ, T_A, SRC_TFC, T_A);
            7'd56: s = mk(OP_SUB, T_TFN, T_A, T_TFN);
            7'd57: s = mk(OP_MULQ, SRC_DT, SRC_WC, T_A);
            7'd58: s = mk(OP_MULQ, T_A, T_DTM, T_A);
            7'd59: s = mk(OP_SUB, T_TFN, T_A, T_TFN);
            7'd60: s = mk(OP_MULQ, T_CDT, SRC_WC, T_A);
            7'd61: s = mk(OP_MULQ, T_A, T_DTF, T_A);
            7'd62: s = mk(OP_SUB, T_TFN, T_A, T_TFN);
            7'd63: s = mk(OP_MULQ, T_CDT, SRC_TFC, T_A);
            7'd64: s = mk(OP_MULQ, T_A, T_DW, T_A);
            7'd65: s = mk(OP_SUB, T_TFN, T_A, T_TFN);
            7'd66: s = mk(OP_MULQ, T_PDT, T_LZ, T_A);
            7'd67: s = mk(OP_ADD, SRC_ZC, T_A, T_ZN);
            7'd68: s = mk(OP_MULQ, T_PDT, SRC_K2, T_A);
            7'd69: s = mk(OP_MULQ, T_A, SRC_ZC, T_A);
            7'd70: s = mk(OP_SUB, T_ZN, T_A, T_ZN);
            7'd71: s = mk(OP_MULQ, T_PDT, SRC_RR, T_A);
            7'd72: s = mk(OP_MULQ, T_A, SRC_K2, T_A);
            7'd73: s = mk(OP_MULQ, T_A, SRC_TFC, T_A);
            7'd74: s = mk(OP_SUB, T_ZN, T_A, T_ZN);
            7'd75: s = mk(OP_ADD, SRC_CC, SRC_CC, T_A);
            7'd76: s = mk(OP_MULQ, T_A, SRC_DT, T_A);
            7'd77: s = mk(OP_MULQ, T_A, SRC_ZC, T_A);
            7'd78: s = mk(OP_MULQ, T_A, T_DW, T_A);
            7'd79: s = mk(OP_SUB, T_ZN, T_A, T_ZN);
            7'd80: s = mk(OP_MULQ, T_CDT, SRC_WC, T_A);
            7'd81: s = mk(OP_MULQ, T_A, T_DZ, T_A);
            7'd82: s = mk(OP_SUB, T_ZN, T_A, T_ZN);
            default: s = mk(OP_ADD, SRC_TMC, SRC_TMC, T_A);
        endcase
        return s;
    endfunction

endpackage

@@ rtl/adaptive_grid_pde_stencil_step.sv @@
// ----------------------------------------------------------------------------
// adaptive_grid_pde_stencil_step
// One explicit Euler step of three coupled fields on an adaptive 1-D grid.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          tm_old tf_old z_old w_old
//                                           subdivision is_last
// result    out        empty / pop          point_index tm_new tf_new z_new
//                                           grid_error last_result
// config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// An interior point runs 83 program steps in the update sequencer, each
// through read, execute and write states on the single shared multiplier
// and adder, plus entry and exit. A grid-error point goes straight to done.
// The front takes one point per cycle until its two-entry job queue is full.
// Reset is asynchronous and clears the window, the queue and the sequencer.
// A result waiting for transfer stalls the sequencer, and then the input once the queue is full.
// ----------------------------------------------------------------------------
module adaptive_grid_pde_stencil_step #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  tm_old,
    input  logic signed [31:0]  tf_old,
    input  logic signed [31:0]  z_old,
    input  logic signed [31:0]  w_old,
    input  logic [7:0]          subdivision,
    input  logic                is_last,
    output logic                empty,
    input  logic                pop,
    output logic [11:0]         point_index,
    output logic signed [31:0]  tm_new,
    output logic signed [31:0]  tf_new,
    output logic signed [31:0]  z_new,
    output logic                grid_error,
    output logic                last_result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    agps_pkg::cfg_t         cfg_reg;
    agps_pkg::job_t         front_job;
    agps_pkg::job_t         q_job;
    agps_pkg::back_status_t back_st;
    logic                   accept;
    logic                   job_push;
    logic                   q_empty;
    logic                   job_take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dt   <= 32'sd0;
            cfg_reg.k2   <= 32'sd0;
            cfg_reg.cc   <= 32'sd0;
            cfg_reg.p    <= 32'sd65536;
            cfg_reg.rr   <= 32'sd0;
            cfg_reg.i2dx <= 32'sd32768;
            cfg_reg.idx2 <= 32'sd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                agps_pkg::REG_DT:   cfg_reg.dt   <= {1'b0, cfg_data[30:0]};
                agps_pkg::REG_K2:   cfg_reg.k2   <= {1'b0, cfg_data[30:0]};
                agps_pkg::REG_CC:   cfg_reg.cc   <= cfg_data;
                agps_pkg::REG_P:    cfg_reg.p    <= {1'b0, cfg_data[30:0]};
                agps_pkg::REG_RR:   cfg_reg.rr   <= cfg_data;
                agps_pkg::REG_I2DX: cfg_reg.i2dx <= {1'b0, cfg_data[30:0]};
                agps_pkg::REG_IDX2: cfg_reg.idx2 <= {1'b0, cfg_data[30:0]};
                default:
                begin
                end
            endcase
        end
    end

    agps_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .tm_old      (tm_old),
        .tf_old      (tf_old),
        .z_old       (z_old),
        .w_old       (w_old),
        .subdivision (subdivision),
        .is_last     (is_last),
        .job         (front_job),
        .job_push    (job_push)
    );

    agps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .in_job  (front_job),
        .full    (full),
        .pop     (job_take),
        .out_job (q_job),
        .empty   (q_empty)
    );

    agps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (q_job),
        .job_valid   (!q_empty),
        .job_take    (job_take),
        .cfg         (cfg_reg),
        .status      (back_st),
        .pop         (pop),
        .empty       (empty),
        .point_index (point_index),
        .tm_new      (tm_new),
        .tf_new      (tf_new),
        .z_new       (z_new),
        .grid_error  (grid_error),
        .last_result (last_result)
    );

`ifndef SYNTHESIS
    a_back_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && back_st.idle) |=> !back_st.idle)
        else $error("sequencer did not take a waiting job");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(back_st.done))
        else $error("result appeared without a finished job");
`endif

endmodule

@@ rtl/agps_front.sv @@
// ----------------------------------------------------------------------------
// agps_front
// Three-point window, stencil classification and job creation per point.
// ----------------------------------------------------------------------------
module agps_front #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic signed [31:0]  tm_old,
    input  logic signed [31:0]  tf_old,
    input  logic signed [31:0]  z_old,
    input  logic signed [31:0]  w_old,
    input  logic [7:0]          subdivision,
    input  logic                is_last,
    output agps_pkg::job_t      job,
    output logic                job_push
);

    localparam int PS_W = $clog2(MAX_POINTS);

    logic [3:0][31:0] prev_reg;
    logic [3:0][31:0] cur_reg;
    logic [7:0]       sl_reg;
    logic [7:0]       sc_reg;
    logic [PS_W-1:0]  ps_reg;

    logic [3:0][31:0] new_val;
    logic [7:0]       sr;
    logic             any_zero;
    logic             all_equal;
    logic             bad_l;
    logic             bad_r;
    logic             err;
    logic [1:0]       mode;
    logic [PS_W-1:0]  idx_short;
    logic [31:0]      idx_ext;

    function automatic logic ratio_bad(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] a3;
        logic [9:0] b3;
        a3 = 10'(a) * 10'd3;
        b3 = 10'(b) * 10'd3;
        return (10'(a) >= b3) || (10'(b) >= a3);
    endfunction

    assign new_val[0] = tm_old;
    assign new_val[1] = tf_old;
    assign new_val[2] = z_old;
    assign new_val[3] = w_old;
    assign sr = subdivision;

    always_comb
    begin
        any_zero  = (sl_reg == 8'd0) || (sc_reg == 8'd0) || (sr == 8'd0);
        all_equal = (sl_reg == sc_reg) && (sc_reg == sr);
        bad_l     = ratio_bad(sc_reg, sl_reg);
        bad_r     = ratio_bad(sc_reg, sr);
        err       = any_zero || (!all_equal && (bad_l || bad_r));
        mode      = agps_pkg::MODE_PLAIN;
        if (!err && !all_equal)
        begin
            if (sc_reg != sl_reg && sc_reg != sr)
            begin
                if (sl_reg != sr)
                begin
                    mode = (sl_reg < sc_reg) ? agps_pkg::MODE_LEFT : agps_pkg::MODE_RIGHT;
                end
            end
            else if (sc_reg == sl_reg)
            begin
                if (sr < sc_reg)
                begin
                    mode = agps_pkg::MODE_RIGHT;
                end
            end
            else if (sl_reg < sc_reg)
            begin
                mode = agps_pkg::MODE_LEFT;
            end
        end
    end

    assign idx_short = ps_reg - PS_W'(1);
    assign idx_ext   = 32'(idx_short);

    always_comb
    begin
        for (int f = 0; f < 4; f++)
        begin
            job.val[f*3]     = prev_reg[f];
            job.val[f*3 + 1] = cur_reg[f];
            job.val[f*3 + 2] = new_val[f];
        end
        job.sd    = sc_reg;
        job.mode  = mode;
        job.err   = err;
        job.index = idx_ext[11:0];
        job.last  = is_last;
    end

    assign job_push = accept && (ps_reg >= PS_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            cur_reg  <= '0;
            sl_reg   <= '0;
            sc_reg   <= '0;
            ps_reg   <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                prev_reg <= '0;
                cur_reg  <= '0;
                sl_reg   <= '0;
                sc_reg   <= '0;
                ps_reg   <= '0;
            end
            else
            begin
                prev_reg <= cur_reg;
                cur_reg  <= new_val;
                sl_reg   <= sc_reg;
                sc_reg   <= sr;
                if (ps_reg < PS_W'(MAX_POINTS - 1))
                begin
                    ps_reg <= ps_reg + PS_W'(1);
                end
            end
        end
    end

endmodule

@@ rtl/agps_queue.sv @@
// ----------------------------------------------------------------------------
// agps_queue
// Two-entry job queue between the classifying front and the update sequencer.
// ----------------------------------------------------------------------------
module agps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  agps_pkg::job_t  in_job,
    output logic            full,
    input  logic            pop,
    output agps_pkg::job_t  out_job,
    output logic            empty
);

    agps_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign out_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/agps_back.sv @@
// ----------------------------------------------------------------------------
// agps_back
// Step sequencer with one shared multiplier and saturating adder that runs
// the field update program and holds the result for transfer.
// ----------------------------------------------------------------------------
module agps_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  agps_pkg::job_t             job,
    input  logic                       job_valid,
    output logic                       job_take,
    input  agps_pkg::cfg_t             cfg,
    output agps_pkg::back_status_t     status,
    input  logic                       pop,
    output logic                       empty,
    output logic [11:0]                point_index,
    output logic signed [31:0]         tm_new,
    output logic signed [31:0]         tf_new,
    output logic signed [31:0]         z_new,
    output logic                       grid_error,
    output logic                       last_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    logic [2:0]          state_reg;
    logic [6:0]          pc_reg;
    agps_pkg::job_t      job_reg;
    logic signed [31:0]  a_reg;
    logic signed [31:0]  b_reg;
    logic [63:0]         prod_reg;
    logic                neg_reg;
    logic signed [31:0]  sum_reg;
    logic signed [31:0]  tmn_reg;
    logic signed [31:0]  tfn_reg;
    logic signed [31:0]  zn_reg;
    logic                out_valid_reg;
    logic [11:0]         out_index_reg;
    logic signed [31:0]  out_tm_reg;
    logic signed [31:0]  out_tf_reg;
    logic signed [31:0]  out_z_reg;
    logic                out_err_reg;
    logic                out_last_reg;
    logic signed [31:0]  tmem [32];

    agps_pkg::step_t     step;
    logic [31:0]         ua;
    logic [31:0]         ub;
    logic [63:0]         prod_next;
    logic signed [31:0]  sum_next;
    logic signed [32:0]  add_w;
    logic signed [32:0]  sub_w;
    logic signed [31:0]  add_s;
    logic signed [31:0]  sub_s;
    logic signed [32:0]  half_w;
    logic signed [31:0]  half_s;
    logic [63:0]         shifted;
    logic [63:0]         lim;
    logic signed [31:0]  mul_s;
    logic signed [31:0]  wr_val;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
        begin
            r = VMAX;
        end
        else if (v < -33'sh0_8000_0000)
        begin
            r = VMIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] operand(input logic [5:0] src,
                                                   input agps_pkg::job_t j,
                                                   input agps_pkg::cfg_t c);
        logic signed [31:0] r;
        unique case (src)
            agps_pkg::SRC_DT:   r = c.dt;
            agps_pkg::SRC_K2:   r = c.k2;
            agps_pkg::SRC_CC:   r = c.cc;
            agps_pkg::SRC_P:    r = c.p;
            agps_pkg::SRC_RR:   r = c.rr;
            agps_pkg::SRC_I2DX: r = c.i2dx;
            agps_pkg::SRC_IDX2: r = c.idx2;
            agps_pkg::SRC_SD:   r = {24'd0, j.sd};
            default:            r = j.val[src[3:0]];
        endcase
        return r;
    endfunction

    assign step = agps_pkg::prog_step(pc_reg);

    assign ua        = a_reg[31] ? 32'(-a_reg) : 32'(a_reg);
    assign ub        = b_reg[31] ? 32'(-b_reg) : 32'(b_reg);
    assign prod_next = ua * ub;

    always_comb
    begin
        add_w  = 33'(a_reg) + 33'(b_reg);
        sub_w  = 33'(a_reg) - 33'(b_reg);
        add_s  = sat33(add_w);
        sub_s  = sat33(sub_w);
        half_w = 33'(add_s) + 33'({31'd0, add_s[31]});
        half_s = half_w[32:1];
        case (step.op)
            agps_pkg::OP_SUB:   sum_next = sub_s;
            agps_pkg::OP_HALFL: sum_next = (job_reg.mode == agps_pkg::MODE_LEFT)
                                           ? half_s : a_reg;
            agps_pkg::OP_HALFR: sum_next = (job_reg.mode == agps_pkg::MODE_RIGHT)
                                           ? half_s : a_reg;
            default:            sum_next = add_s;
        endcase
    end

    always_comb
    begin
        shifted = (step.op == agps_pkg::OP_MULQ) ? (prod_reg >> agps_pkg::FRAC_BITS)
                                                 : prod_reg;
        lim     = neg_reg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (shifted > lim)
        begin
            mul_s = neg_reg ? VMIN : VMAX;
        end
        else
        begin
            mul_s = neg_reg ? -$signed(shifted[31:0]) : $signed(shifted[31:0]);
        end
        wr_val = (step.op == agps_pkg::OP_MULQ || step.op == agps_pkg::OP_MUL0)
                 ? mul_s : sum_reg;
    end

    assign job_take    = (state_reg == ST_IDLE) && job_valid;
    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    assign empty       = !out_valid_reg;
    assign point_index = out_index_reg;
    assign tm_new      = out_tm_reg;
    assign tf_new      = out_tf_reg;
    assign z_new       = out_z_reg;
    assign grid_error  = out_err_reg;
    assign last_result = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_READ)
        begin
            a_reg <= step.a[5] ? tmem[step.a[4:0]] : operand(step.a, job_reg, cfg);
            b_reg <= step.b[5] ? tmem[step.b[4:0]] : operand(step.b, job_reg, cfg);
        end
        if (state_reg == ST_EXEC)
        begin
            prod_reg <= prod_next;
            neg_reg  <= a_reg[31] ^ b_reg[31];
            sum_reg  <= sum_next;
        end
        if (state_reg == ST_WRITE)
        begin
            tmem[step.dst[4:0]] <= wr_val;
            if (step.dst == agps_pkg::T_TMN)
            begin
                tmn_reg <= wr_val;
            end
            if (step.dst == agps_pkg::T_TFN)
            begin
                tfn_reg <= wr_val;
            end
            if (step.dst == agps_pkg::T_ZN)
            begin
                zn_reg <= wr_val;
            end
        end
        if (state_reg == ST_IDLE && job_valid && job.err)
        begin
            tmn_reg <= job.val[agps_pkg::SRC_TMC[3:0]];
            tfn_reg <= job.val[agps_pkg::SRC_TFC[3:0]];
            zn_reg  <= job.val[agps_pkg::SRC_ZC[3:0]];
        end
        if (state_reg == ST_DONE && !out_valid_reg)
        begin
            out_index_reg <= job_reg.index;
            out_tm_reg    <= tmn_reg;
            out_tf_reg    <= tfn_reg;
            out_z_reg     <= zn_reg;
            out_err_reg   <= job_reg.err;
            out_last_reg  <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        pc_reg    <= '0;
                        state_reg <= job.err ? ST_DONE : ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (pc_reg == 7'(agps_pkg::PROG_LEN - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 7'd1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
